[rtl/core/i2cmts_pkg.sv]
// types and constants shared by the i2c transaction sequencer
package i2cmts_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SLAVE_ADDRESS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACCESS_MODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WRITE_COUNT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_READ_COUNT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRITE_DATA    = 3'd4;

  // two-wire bus status codes
  localparam logic [7:0] ST_START_SENT    = 8'h08;
  localparam logic [7:0] ST_RESTART_SENT  = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK    = 8'h18;
  localparam logic [7:0] ST_DATA_TX_ACK   = 8'h28;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK    = 8'h40;
  localparam logic [7:0] ST_DATA_RX_ACK   = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK  = 8'h58;

  // action codes
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_write_t;

  typedef struct packed {
    logic       action;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       send_start;
    logic       send_stop;
    logic       send_ack;
    logic       keep_engaged;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [1:0] rx_index;
    logic       done_res;
    logic       bus_error;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [6:0]  slave_address;
    logic [2:0]  access_mode;
    logic [2:0]  write_count;
    logic [2:0]  read_count;
    logic [31:0] write_data;
  } cfg_t;

  typedef struct packed {
    logic       write_pending;
    logic       read_pending;
    logic       hold_bus;
    logic [2:0] byte_position;
  } seq_state_t;

  // decoder output toward the top level
  typedef struct packed {
    seq_state_t state_d;
    result_t    res0;
    result_t    res1;
    logic       two;
  } step_t;

endpackage

[rtl/core/i2cmts_if.sv]
// valid/ready channel interfaces for config, items and results
interface i2cmts_cfg_if;
  logic                   valid;
  logic                   ready;
  i2cmts_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmts_item_if;
  logic              valid;
  logic              ready;
  i2cmts_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmts_result_if;
  logic                valid;
  logic                ready;
  i2cmts_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2cmts_step.sv]
// status decoder: next sequencer state and one or two results per item
module i2cmts_step #(
  parameter int unsigned MAX_BYTES = 4
) (
  input  i2cmts_pkg::item_t      item_i,
  input  i2cmts_pkg::cfg_t       cfg_i,
  input  i2cmts_pkg::seq_state_t state_i,
  output i2cmts_pkg::step_t      step_o
);
  import i2cmts_pkg::*;

  localparam logic [3:0] MaxB = 4'(MAX_BYTES);

  logic [3:0] wlim;
  logic [3:0] rlim;
  logic [2:0] pos_inc;
  logic [7:0] wbyte;
  step_t      s;

  assign wlim = ({1'b0, cfg_i.write_count} > MaxB) ? MaxB : {1'b0, cfg_i.write_count};
  assign rlim = ({1'b0, cfg_i.read_count} > MaxB) ? MaxB : {1'b0, cfg_i.read_count};
  assign pos_inc = (state_i.byte_position == 3'd7) ? 3'd7 : state_i.byte_position + 3'd1;
  // bytes past the fourth go out as zero
  assign wbyte = state_i.byte_position[2] ? 8'h00
               : cfg_i.write_data[{state_i.byte_position[1:0], 3'b000} +: 8];

  always_comb begin
    s = '0;
    s.state_d = state_i;
    s.res0.last = 1'b1;
    if (item_i.action == ACT_BEGIN) begin
      s.state_d.read_pending = cfg_i.access_mode[0];
      s.state_d.write_pending = cfg_i.access_mode[1];
      s.state_d.hold_bus = cfg_i.access_mode[2];
      s.state_d.byte_position = 3'd0;
      s.res0.send_start = 1'b1;
      s.res0.keep_engaged = 1'b1;
    end else begin
      unique case (item_i.status_code) inside
        ST_START_SENT, ST_RESTART_SENT: begin
          s.state_d.byte_position = 3'd0;
          s.res0.tx_valid = 1'b1;
          s.res0.keep_engaged = 1'b1;
          s.res0.tx_byte = {cfg_i.slave_address, ~state_i.write_pending};
        end
        ST_ADDR_W_ACK, ST_DATA_TX_ACK: begin
          if ({1'b0, state_i.byte_position} < wlim) begin
            s.res0.tx_valid = 1'b1;
            s.res0.keep_engaged = 1'b1;
            s.res0.tx_byte = wbyte;
            s.state_d.byte_position = pos_inc;
          end else begin
            s.state_d.write_pending = 1'b0;
            s.state_d.hold_bus = 1'b0;
            if (state_i.read_pending) begin
              if (!state_i.hold_bus) begin
                // stop, then a fresh start for the read phase
                s.res0.send_stop = 1'b1;
                s.res0.keep_engaged = 1'b1;
                s.res0.last = 1'b0;
                s.res1.send_start = 1'b1;
                s.res1.keep_engaged = 1'b1;
                s.res1.last = 1'b1;
                s.two = 1'b1;
              end else begin
                s.res0.send_start = 1'b1;
                s.res0.keep_engaged = 1'b1;
              end
            end else begin
              s.res0.send_stop = ~state_i.hold_bus;
              s.res0.done_res = 1'b1;
            end
          end
        end
        ST_DATA_RX_ACK: begin
          s.res0.rx_valid = 1'b1;
          s.res0.rx_data = item_i.rx_byte;
          s.res0.rx_index = state_i.byte_position[1:0];
          s.state_d.byte_position = pos_inc;
          s.res0.keep_engaged = 1'b1;
          s.res0.send_ack = ({1'b0, pos_inc} + 4'd1) < rlim;
        end
        ST_ADDR_R_ACK: begin
          s.res0.keep_engaged = 1'b1;
          s.res0.send_ack = ({1'b0, state_i.byte_position} + 4'd1) < rlim;
        end
        ST_DATA_RX_NACK: begin
          s.res0.rx_valid = 1'b1;
          s.res0.rx_data = item_i.rx_byte;
          s.res0.rx_index = state_i.byte_position[1:0];
          s.state_d.byte_position = pos_inc;
          s.state_d.read_pending = 1'b0;
          s.res0.send_stop = 1'b1;
          s.res0.done_res = ~state_i.write_pending;
        end
        ST_ARB_LOST: begin
          s.res0.send_start = 1'b1;
          s.res0.keep_engaged = 1'b1;
        end
        default: begin
          s.res0.bus_error = 1'b1;
        end
      endcase
    end
  end

  assign step_o = s;

endmodule

[rtl/core/i2c_master_transaction_sequencer.sv]
// top level of the i2c master transaction sequencer
//
// usage
// - cfg_i: register writes (index, data), always ready; write only while the
//   sequencer has no item in flight and all results have been taken
// - item_i: begin items and bus status events from the byte engine
// - result_o: commands and received bytes for the byte engine; an item gives
//   one result, or two (stop then start) when a write ends before a read
//   without a held bus; the last flag marks the final result of an item
// data path and throughput
// - an item taken on item_i sits in the input register and is decoded from
//   there into the output queue, from which its first result is offered
// - one item per cycle sustained while result_o is ready and each item gives
//   one result; the four-entry output queue takes a new decode while it
//   holds at most two results
// reset
// - clears config, sequencer state, input valid and queue counters; no result is pending
// stall
// - when result_o is stalled the queue fills, the input register holds its
//   item and item_i.ready drops; nothing is lost or repeated
module i2c_master_transaction_sequencer #(
  parameter int unsigned MAX_BYTES = 4
) (
  input logic             clk_i,
  input logic             rst_ni,
  i2cmts_cfg_if.sink      cfg_i,
  i2cmts_item_if.sink     item_i,
  i2cmts_result_if.source result_o
);
  import i2cmts_pkg::*;

  localparam int unsigned QDepth = 4;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // sequencer state
  seq_state_t state_q;

  // input register
  logic  stage_valid_q;
  item_t stage_item_q;

  // output queue
  result_t    queue_q [QDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  step_t      step;
  logic       advance;
  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] push_n;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_SLAVE_ADDRESS: cfg_d.slave_address = cfg_i.data.data[6:0];
        REG_ACCESS_MODE:   cfg_d.access_mode = cfg_i.data.data[2:0];
        REG_WRITE_COUNT:   cfg_d.write_count = cfg_i.data.data[2:0];
        REG_READ_COUNT:    cfg_d.read_count = cfg_i.data.data[2:0];
        REG_WRITE_DATA:    cfg_d.write_data = cfg_i.data.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  i2cmts_step #(
    .MAX_BYTES(MAX_BYTES)
  ) u_step (
    .item_i (stage_item_q),
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .step_o (step)
  );

  // decode moves into the queue only with room for two results
  assign advance  = stage_valid_q && (count_q <= 3'(QDepth - 2));
  assign item_i.ready = !stage_valid_q || advance;
  assign in_xfer  = item_i.valid && item_i.ready;
  assign out_xfer = result_o.valid && result_o.ready;
  assign push_n   = advance ? (step.two ? 2'd2 : 2'd1) : 2'd0;

  assign result_o.valid = (count_q != 3'd0);
  assign result_o.data  = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= '0;
      state_q       <= '0;
      stage_valid_q <= 1'b0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_d;
      end
      if (advance) begin
        state_q <= step.state_d;
      end
      if (in_xfer) begin
        stage_valid_q <= 1'b1;
      end else if (advance) begin
        stage_valid_q <= 1'b0;
      end
      wr_ptr_q <= wr_ptr_q + push_n;
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_n} - {2'b00, out_xfer};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_item_q <= item_i.data;
    end
    if (advance) begin
      queue_q[wr_ptr_q] <= step.res0;
      if (step.two) begin
        queue_q[wr_ptr_q + 2'd1] <= step.res1;
      end
    end
  end

endmodule
